/* hw/rtl/gbcs_pkg.sv */
package gbcs_pkg;

  localparam int DATA_W  = 32;
  localparam int ENTRY_W = 3 * DATA_W;

  // controller to datapath
  typedef struct packed {
    logic lookup;
    logic update;
    logic drain_rd;
    logic drain_load;
    logic clear;
  } gbcs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_row;
    logic drain_end;
    logic out_free;
  } gbcs_sts_t;

endpackage

/* hw/rtl/gbcs_ram.sv */
module gbcs_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/gbcs_ctrl.sv */
module gbcs_ctrl
  import gbcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  gbcs_sts_t sts,
  output gbcs_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_DRD  = 2'd2;
  localparam logic [1:0] ST_DOUT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    in_stall       = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.lookup = in_valid;
        if (in_valid) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = sts.last_row ? ST_DRD : ST_IDLE;
      end
      ST_DRD: begin
        cmd.drain_rd = 1'b1;
        state_nxt    = ST_DOUT;
      end
      ST_DOUT: begin
        if (sts.out_free) begin
          cmd.drain_load = 1'b1;
          cmd.clear      = sts.drain_end;
          state_nxt      = sts.drain_end ? ST_IDLE : ST_DRD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/gbcs_dp.sv */
module gbcs_dp
  import gbcs_pkg::*;
#(
  parameter int GROUPS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  gbcs_cmd_t                cmd,
  output gbcs_sts_t                sts,
  input  logic signed [DATA_W-1:0] in_group_key,
  input  logic signed [DATA_W-1:0] in_row_value,
  input  logic                     in_is_dummy,
  input  logic                     in_last_row,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_key,
  output logic        [DATA_W-1:0] out_row_count,
  output logic signed [DATA_W-1:0] out_value_sum,
  output logic                     out_last_group,
  output logic                     out_overflowed
);

  localparam int IDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int CNT_W = $clog2(GROUPS + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(GROUPS);
  localparam logic [DATA_W-1:0] CNT_MAX = '1;

  // key compare array, one register per group
  logic [DATA_W-1:0] key_cam_r [GROUPS];
  logic [GROUPS-1:0] hit_vec;
  logic              hit_any;
  logic [IDX_W-1:0]  hit_idx;

  logic [CNT_W-1:0]  total_r;
  logic              ovf_r;
  logic [IDX_W-1:0]  drain_idx_r;

  logic [DATA_W-1:0] key_r;
  logic [DATA_W-1:0] add_r;
  logic              last_r;
  logic              hit_r;
  logic [IDX_W-1:0]  hit_idx_r;

  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [IDX_W-1:0]   ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;

  logic [DATA_W-1:0] rd_key;
  logic [DATA_W-1:0] rd_count;
  logic [DATA_W-1:0] rd_sum;
  logic [DATA_W-1:0] count_inc;
  logic              room;
  logic              open_grp;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_key_r;
  logic [DATA_W-1:0] out_count_r;
  logic [DATA_W-1:0] out_sum_r;
  logic              out_last_r;
  logic              out_ovf_r;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < GROUPS; i++) begin
      hit_vec[i] = (CNT_W'(i) < total_r) && (key_cam_r[i] == in_group_key);
      hit_idx    = hit_idx | (hit_vec[i] ? IDX_W'(i) : '0);
    end
    hit_any = |hit_vec;
  end

  assign rd_key    = ram_rd_data[3*DATA_W-1:2*DATA_W];
  assign rd_count  = ram_rd_data[2*DATA_W-1:DATA_W];
  assign rd_sum    = ram_rd_data[DATA_W-1:0];
  assign count_inc = (rd_count == CNT_MAX) ? rd_count : rd_count + 1'b1;
  assign room      = total_r < FULL;
  assign open_grp  = cmd.update && !hit_r && room;

  always_comb begin
    ram_wr_en   = cmd.update && (hit_r || room);
    ram_wr_addr = hit_r ? hit_idx_r : total_r[IDX_W-1:0];
    ram_wr_data = hit_r ? {rd_key, count_inc, rd_sum + add_r}
                        : {key_r, DATA_W'(1), add_r};
    ram_rd_en   = cmd.lookup || cmd.drain_rd;
    ram_rd_addr = cmd.drain_rd ? drain_idx_r : hit_idx;
  end

  gbcs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (GROUPS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // row capture and key array
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      key_r     <= in_group_key;
      add_r     <= in_is_dummy ? '0 : in_row_value;
      last_r    <= in_last_row;
      hit_r     <= hit_any;
      hit_idx_r <= hit_idx;
    end
    if (open_grp) begin
      key_cam_r[total_r[IDX_W-1:0]] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      ovf_r       <= 1'b0;
      drain_idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        total_r     <= '0;
        ovf_r       <= 1'b0;
        drain_idx_r <= '0;
      end else begin
        if (open_grp) begin
          total_r <= total_r + 1'b1;
        end
        if (cmd.update && !hit_r && !room) begin
          ovf_r <= 1'b1;
        end
        if (cmd.drain_load) begin
          drain_idx_r <= drain_idx_r + 1'b1;
        end
      end
      if (cmd.drain_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain_load) begin
      out_key_r   <= rd_key;
      out_count_r <= rd_count;
      out_sum_r   <= rd_sum;
      out_last_r  <= sts.drain_end;
      out_ovf_r   <= ovf_r;
    end
  end

  assign sts.last_row  = last_r;
  assign sts.drain_end = (CNT_W'(drain_idx_r) + 1'b1) == total_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_key        = out_key_r;
  assign out_row_count  = out_count_r;
  assign out_value_sum  = out_sum_r;
  assign out_last_group = out_last_r;
  assign out_overflowed = out_ovf_r;

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= FULL) else $error("group count beyond table size");

  a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec)) else $error("key found in more than one group");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> total_r == FULL) else $error("overflow set with free entries");

  a_open_grows: assert property (@(posedge clk) disable iff (!rst_n)
    open_grp && !cmd.clear |=> total_r == $past(total_r) + 1'b1)
    else $error("new group did not advance the group count");
`endif

endmodule

/* hw/rtl/group_by_count_sum.sv */
// grouped count and sum over a batch of table rows. each input beat is one row: its key is
// compared against every open group at once; a hit bumps that group's saturating count and
// adds the value (zero for a dummy row) to its wrapping 32-bit sum, a miss opens a new group
// at the next free entry, or drops the row and sets a sticky overflow flag when all GROUPS
// entries are taken. a row is a compare plus entry read, then a read-modify-write of the
// single group ram; no new row is taken before that write. after the row marked last, the
// open groups stream out in the order they were opened, each as a ram read, then an output
// register load that waits out an output stall; the final group carries out_last_group, every
// group of the batch carries the overflow flag, and the table empties with that last beat.
// no rows are taken during this drain. no clearing pass is needed after reset.
module group_by_count_sum
  import gbcs_pkg::*;
#(
  parameter int GROUPS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // row input
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_group_key,
  input  logic signed [DATA_W-1:0] in_row_value,
  input  logic                     in_is_dummy,
  input  logic                     in_last_row,
  // group results
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_key,
  output logic        [DATA_W-1:0] out_row_count,
  output logic signed [DATA_W-1:0] out_value_sum,
  output logic                     out_last_group,
  output logic                     out_overflowed
);

  gbcs_cmd_t cmd;
  gbcs_sts_t sts;

  // sequencer: accept, update, then drain loop on the last row
  gbcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // key compare array, group ram, counters and output register
  gbcs_dp #(
    .GROUPS (GROUPS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_group_key   (in_group_key),
    .in_row_value   (in_row_value),
    .in_is_dummy    (in_is_dummy),
    .in_last_row    (in_last_row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_key        (out_key),
    .out_row_count  (out_row_count),
    .out_value_sum  (out_value_sum),
    .out_last_group (out_last_group),
    .out_overflowed (out_overflowed)
  );

endmodule

/* sim/tb_group_by_count_sum.sv */
module tb_group_by_count_sum
  import gbcs_pkg::*;
;

  localparam int GROUPS         = 64;
  // random rows after the directed table
  localparam int RANDOM_ROWS    = 363;
  // cycles with no beat on either side before the run is called hung
  localparam int WATCHDOG_LIMIT = 1000;
  // quiet cycles after the last expected group, catches stray beats
  localparam int TAIL_CYCLES    = 40;
  localparam int REPORT_LIMIT   = 10;
  // last random rows run with no idling on either side
  localparam int QUIET_ROWS     = 60;

  localparam logic signed [DATA_W-1:0] INT_MIN   = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] INT_MAX   = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] NEG_ONE   = 32'shffff_ffff;
  localparam logic        [DATA_W-1:0] COUNT_MAX = 32'hffff_ffff;

  // one result beat: a closed group
  typedef struct packed {
    logic signed [DATA_W-1:0] key;
    logic        [DATA_W-1:0] count;
    logic signed [DATA_W-1:0] sum;
    logic                     last;
    logic                     ovf;
  } group_beat_t;

  // one row beat, plus a hand-written group for rows whose batch closes
  // with a single obvious group
  typedef struct packed {
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
    logic                     dummy;
    logic                     last;
    logic                     typed;
    group_beat_t              want;
  } table_row_t;

  localparam int DIRECTED_N = 17;
  localparam table_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    // single-row batches at the key and value extremes
    '{INT_MIN, INT_MAX, 1'b0, 1'b1, 1'b1, '{INT_MIN, 32'd1, INT_MAX, 1'b1, 1'b0}},
    // dummy row opens a group with a zero sum
    '{INT_MAX, INT_MIN, 1'b1, 1'b1, 1'b1, '{INT_MAX, 32'd1, 32'sd0, 1'b1, 1'b0}},
    '{32'sd0, NEG_ONE, 1'b0, 1'b1, 1'b1, '{32'sd0, 32'd1, NEG_ONE, 1'b1, 1'b0}},
    '{NEG_ONE, 32'sd0, 1'b0, 1'b1, 1'b1, '{NEG_ONE, 32'd1, 32'sd0, 1'b1, 1'b0}},
    // positive sum wraps to the most negative value
    '{32'sd5, INT_MAX, 1'b0, 1'b0, 1'b0, '0},
    '{32'sd5, 32'sd1, 1'b0, 1'b1, 1'b1, '{32'sd5, 32'd2, INT_MIN, 1'b1, 1'b0}},
    // group made of dummies only
    '{32'sd3, 32'sd10, 1'b1, 1'b0, 1'b0, '0},
    '{32'sd3, 32'sd20, 1'b1, 1'b1, 1'b1, '{32'sd3, 32'd2, 32'sd0, 1'b1, 1'b0}},
    // interleaved keys, insertion order on the drain
    '{32'sd7, 32'sd3, 1'b0, 1'b0, 1'b0, '0},
    '{-32'sd7, 32'sd4, 1'b0, 1'b0, 1'b0, '0},
    '{32'sd7, 32'sd100, 1'b1, 1'b0, 1'b0, '0},
    '{-32'sd7, -32'sd4, 1'b0, 1'b0, 1'b0, '0},
    '{32'sd7, INT_MIN, 1'b0, 1'b0, 1'b0, '0},
    '{32'sd9, 32'sd0, 1'b0, 1'b1, 1'b0, '0},
    // negative sum wraps back to zero
    '{INT_MIN, INT_MIN, 1'b0, 1'b0, 1'b0, '0},
    '{INT_MIN, INT_MIN, 1'b0, 1'b1, 1'b1, '{INT_MIN, 32'd2, 32'sd0, 1'b1, 1'b0}},
    '{32'sd0, 32'sd0, 1'b1, 1'b1, 1'b1, '{32'sd0, 32'd1, 32'sd0, 1'b1, 1'b0}}
  };

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_group_key;
  logic signed [DATA_W-1:0] in_row_value;
  logic                     in_is_dummy;
  logic                     in_last_row;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] out_key;
  logic        [DATA_W-1:0] out_row_count;
  logic signed [DATA_W-1:0] out_value_sum;
  logic                     out_last_group;
  logic                     out_overflowed;

  // predicted table contents for the open batch
  logic [DATA_W-1:0] open_key   [GROUPS];
  logic [DATA_W-1:0] open_count [GROUPS];
  logic [DATA_W-1:0] open_sum   [GROUPS];
  int                open_total     = 0;
  logic              batch_overflow = 1'b0;

  // closed groups still owed by the block, oldest first
  group_beat_t groups_due [$];

  int mismatch_count = 0;
  bit idling_on      = 1'b1;

  group_by_count_sum #(
    .GROUPS(GROUPS)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_group_key  (in_group_key),
    .in_row_value  (in_row_value),
    .in_is_dummy   (in_is_dummy),
    .in_last_row   (in_last_row),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_key       (out_key),
    .out_row_count (out_row_count),
    .out_value_sum (out_value_sum),
    .out_last_group(out_last_group),
    .out_overflowed(out_overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // append one closed group to the owed list
  task automatic owe_group(input group_beat_t grp);
    groups_due = {groups_due, grp};
  endtask

  // drive one row beat, hold it until taken, then fold it into the
  // predicted table; a last row closes the batch into groups_due
  task automatic send_row(input table_row_t row);
    logic        hit;
    group_beat_t beat;
    @(negedge clk);
    in_group_key <= row.key;
    in_row_value <= row.value;
    in_is_dummy  <= row.dummy;
    in_last_row  <= row.last;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hit = 1'b0;
    for (int g = 0; g < open_total; g++) begin
      if (!hit && open_key[g] == row.key) begin
        hit = 1'b1;
        // count saturates, sum wraps
        if (open_count[g] != COUNT_MAX) open_count[g] = open_count[g] + 1;
        if (!row.dummy) open_sum[g] = open_sum[g] + row.value;
      end
    end
    if (!hit) begin
      if (open_total < GROUPS) begin
        open_key[open_total]   = row.key;
        open_count[open_total] = 1;
        open_sum[open_total]   = row.dummy ? '0 : row.value;
        open_total++;
      end else begin
        // table full: row dropped, flag sticks for the batch
        batch_overflow = 1'b1;
      end
    end
    if (row.last) begin
      if (row.typed) begin
        owe_group(row.want);
      end else begin
        for (int g = 0; g < open_total; g++) begin
          beat.key   = open_key[g];
          beat.count = open_count[g];
          beat.sum   = open_sum[g];
          beat.last  = (g == open_total - 1);
          beat.ovf   = batch_overflow;
          owe_group(beat);
        end
      end
      open_total     = 0;
      batch_overflow = 1'b0;
    end
    // random sender gap of random length after roughly one row in five
    if (idling_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 13)) @(negedge clk);
    end
  endtask

  // hold off rows until every owed group has come out
  task automatic wait_for_groups();
    @(negedge clk);
    in_valid <= 1'b0;
    while (groups_due.size() != 0) @(posedge clk);
  endtask

  // receiver stall bursts of random length
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idling_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // compare each taken group beat with the oldest owed group
  always @(posedge clk) begin : check_groups
    group_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (groups_due.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT)
          $display("unexpected group beat: key=%h count=%h sum=%h last=%b ovf=%b",
                   out_key, out_row_count, out_value_sum, out_last_group, out_overflowed);
        mismatch_count++;
      end else begin
        want = groups_due.pop_front();
        if (out_key !== want.key || out_row_count !== want.count ||
            out_value_sum !== want.sum || out_last_group !== want.last ||
            out_overflowed !== want.ovf) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("group mismatch: expected key=%h count=%h sum=%h last=%b ovf=%b",
                     want.key, want.count, want.sum, want.last, want.ovf);
            $display("                actual   key=%h count=%h sum=%h last=%b ovf=%b",
                     out_key, out_row_count, out_value_sum, out_last_group, out_overflowed);
          end
          mismatch_count++;
        end
      end
    end
  end

  // hang detection: no beat on either side for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAIL group_by_count_sum");
    $finish;
  end

  initial begin : stimulus
    table_row_t        row;
    logic [DATA_W-1:0] pool [8];
    logic [DATA_W-1:0] fill_base;
    logic [DATA_W-1:0] fill_step;
    int                pool_n;
    int                batch_len;
    int                batch_no;
    int                rows_sent;
    bit                pressure_done;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_group_key  = '0;
    in_row_value  = '0;
    in_is_dummy   = 1'b0;
    in_last_row   = 1'b0;
    batch_no      = 0;
    rows_sent     = 0;
    pressure_done = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int r = 0; r < DIRECTED_N; r++) send_row(DIRECTED_ROWS[r]);

    // random batches
    while (rows_sent < RANDOM_ROWS) begin
      if (RANDOM_ROWS - rows_sent < QUIET_ROWS) idling_on = 1'b0;
      // one full pause mid-run: sender waits out the whole drain
      if (!pressure_done && rows_sent > RANDOM_ROWS / 2) begin
        wait_for_groups();
        pressure_done = 1'b1;
      end
      // odd step keeps the fill keys distinct
      fill_base = $urandom;
      fill_step = $urandom | 1;
      if (batch_no == 3 || batch_no == 6) begin
        // fill every entry of the table
        for (int g = 0; g < GROUPS; g++) begin
          row       = '0;
          row.key   = fill_base + g * fill_step;
          row.value = $urandom;
          row.dummy = ($urandom_range(0, 3) == 0);
          send_row(row);
        end
        rows_sent += GROUPS;
        if (batch_no == 6) begin
          // table full: new keys dropped, known keys still counted
          for (int j = 0; j < 8; j++) begin
            row       = '0;
            row.key   = $urandom_range(0, 1) ? fill_base + (GROUPS + j) * fill_step
                                             : fill_base + $urandom_range(0, GROUPS - 1) * fill_step;
            row.value = $urandom;
            row.dummy = ($urandom_range(0, 3) == 0);
            send_row(row);
          end
          rows_sent += 8;
          // last row itself is a dropped new key
          row.key = fill_base + (GROUPS + 8) * fill_step;
        end else begin
          // exactly full, last row hits a known group
          row.key = fill_base + $urandom_range(0, GROUPS - 1) * fill_step;
        end
        row.value = $urandom;
        row.dummy = ($urandom_range(0, 3) == 0);
        row.last  = 1'b1;
        send_row(row);
        rows_sent++;
      end else begin
        // small batch over a few keys so most rows hit an open group
        pool_n = $urandom_range(1, 6);
        for (int j = 0; j < pool_n; j++)
          pool[j] = ($urandom_range(0, 7) == 0) ? (j[0] ? INT_MAX : INT_MIN) : $urandom;
        batch_len = $urandom_range(1, 16);
        for (int j = 0; j < batch_len; j++) begin
          row       = '0;
          row.key   = ($urandom_range(0, 9) == 0) ? $urandom
                                                  : pool[$urandom_range(0, pool_n - 1)];
          row.value = $urandom;
          row.dummy = ($urandom_range(0, 3) == 0);
          row.last  = (j == batch_len - 1);
          send_row(row);
        end
        rows_sent += batch_len;
      end
      batch_no++;
    end

    // let the last drain finish, then watch for stray beats
    wait_for_groups();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && groups_due.size() == 0) begin
      $display("PASS group_by_count_sum");
    end else begin
      $display("FAIL group_by_count_sum");
    end
    $finish;
  end

endmodule
